/* src/redundancy_allocation_reliability_dp_core_assert.svh */
// Assertion macros for the reliability allocation core.
// Used by the top level only; no other dependencies.
`ifndef REDUNDANCY_ALLOCATION_RELIABILITY_DP_CORE_ASSERT_SVH
`define REDUNDANCY_ALLOCATION_RELIABILITY_DP_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define RAR_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication.
`define RAR_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

/* src/rar_pkg.sv */
// Shared types and constants for the reliability allocation core.
// No dependencies.
`timescale 1ns / 1ps
package rar_pkg;
    localparam int MAX_SPARE = 1024;
    localparam int FRAC_BITS = 31;
    localparam int ROW_LEN = MAX_SPARE + 1;
    localparam int IDX_W = $clog2(ROW_LEN);
    localparam logic [31:0] ONE = 32'h8000_0000;
    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_ZERO_PROB = 3'd1;
    localparam logic [2:0] ST_SHORT = 3'd2;
    localparam logic [2:0] ST_SPARE = 3'd3;
    localparam logic [2:0] ST_ZERO_COST = 3'd4;

    typedef struct packed {
        logic load;       // latch the beat, start a stage
        logic clr_start;  // start clearing pass
        logic j_init;     // begin entry j: z = 0
        logic rd;         // issue row read at j - used
        logic mul_q;      // compute next qpow and candidate
        logic mul_r;      // keep the larger of candidate and best
        logic step;       // used += cost
        logic wr;         // write best to row[j]
        logic j_dec;      // move to next j
        logic clr_wr;     // clear one entry
        logic fin_rd;     // read result entry
    } rar_cmd_t;

    typedef struct packed {
        logic more_z;     // another copy fits
        logic j_zero;     // j is at 0
        logic clr_done;   // clearing pass at last entry
        logic last;       // stage ends the set
    } rar_sts_t;
endpackage

/* src/rar_ctrl.sv */
// Sequencer for the reliability allocation core.
// Depends on rar_pkg.
`timescale 1ns / 1ps
module rar_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output rar_pkg::rar_cmd_t cmd,
    input  rar_pkg::rar_sts_t sts
);
    typedef enum logic [3:0]
    {
        S_CLEAR, S_IDLE, S_JINIT, S_RD, S_MULQ, S_MULR, S_ACC, S_WR,
        S_FIN, S_FIN2, S_OUT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:  cmd.load = in_valid;
            S_JINIT: cmd.j_init = 1'b1;
            S_RD:    cmd.rd = 1'b1;
            S_MULQ:  cmd.mul_q = 1'b1;
            S_MULR:  cmd.mul_r = 1'b1;
            S_ACC:   cmd.step = sts.more_z;
            S_WR:
            begin
                cmd.wr = 1'b1;
                cmd.j_dec = !sts.j_zero;
            end
            S_FIN:   cmd.fin_rd = 1'b1;
            S_OUT:   cmd.clr_start = out_ready;
            S_CLEAR: cmd.clr_wr = 1'b1;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR: if (sts.clr_done) state_reg <= S_IDLE;
                S_IDLE:  if (in_valid) state_reg <= S_JINIT;
                S_JINIT: state_reg <= S_RD;
                S_RD:    state_reg <= S_MULQ;
                S_MULQ:  state_reg <= S_MULR;
                S_MULR:  state_reg <= S_ACC;
                S_ACC:   state_reg <= sts.more_z ? S_RD : S_WR;
                S_WR:
                begin
                    if (!sts.j_zero)
                        state_reg <= S_JINIT;
                    else if (sts.last)
                        state_reg <= S_FIN;
                    else
                        state_reg <= S_IDLE;
                end
                S_FIN:   state_reg <= S_FIN2;
                S_FIN2:
                begin
                    state_reg     <= S_OUT;
                    out_valid_reg <= 1'b1;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_CLEAR;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

/* src/rar_dp.sv */
// Datapath: row memory, two Q1.31 multipliers, flags and result.
// Depends on rar_pkg.
`timescale 1ns / 1ps
module rar_dp
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [31:0]       stage_probability,
    input  logic [15:0]       stage_cost,
    input  logic              last_stage,
    input  logic [19:0]       total_budget,
    input  rar_pkg::rar_cmd_t cmd,
    output rar_pkg::rar_sts_t sts,
    output logic [31:0]       best_reliability,
    output logic [2:0]        status
);
    localparam int IW = rar_pkg::IDX_W;

    logic [31:0]   row_mem [rar_pkg::ROW_LEN];
    logic [31:0]   rd_data_reg;
    logic [31:0]   q_reg, qpow_reg, qnext_reg, best_reg, cand_reg;
    logic [15:0]   cost_reg;
    logic          last_reg;
    logic [IW-1:0] j_reg, clr_reg;
    logic [IW:0]   used_reg;
    logic [31:0]   cost_total_reg;
    logic          zp_reg, zc_reg;
    logic [31:0]   res_reg;
    logic [2:0]    st_reg;
    logic [31:0]   p_clamp;
    logic [32:0]   ct_sum;
    logic [63:0]   prod_q, prod_r;
    logic [IW-1:0] rd_addr;
    logic [17:0]   used_plus;
    logic [31:0]   spare;

    assign p_clamp   = (stage_probability > rar_pkg::ONE) ? rar_pkg::ONE : stage_probability;
    assign ct_sum    = {1'b0, cost_total_reg} + {17'd0, stage_cost};
    assign used_plus = {{(17 - IW){1'b0}}, used_reg} + {2'd0, cost_reg};
    assign rd_addr   = j_reg - used_reg[IW-1:0];
    assign prod_q    = qpow_reg * q_reg;
    assign prod_r    = rd_data_reg * (rar_pkg::ONE - qpow_reg);
    assign spare     = {12'd0, total_budget} - cost_total_reg;

    assign sts.more_z   = (cost_reg != 16'd0) && (used_plus <= {{(18 - IW){1'b0}}, j_reg});
    assign sts.j_zero   = (j_reg == '0);
    assign sts.clr_done = (clr_reg == IW'(rar_pkg::MAX_SPARE));
    assign sts.last     = last_reg;

    assign best_reliability = res_reg;
    assign status           = st_reg;

    // Row memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
            row_mem[clr_reg] <= rar_pkg::ONE;
        else if (cmd.wr)
            row_mem[j_reg] <= best_reg;
        if (cmd.rd)
            rd_data_reg <= row_mem[rd_addr];
        else if (cmd.fin_rd)
            rd_data_reg <= row_mem[spare[IW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            q_reg    <= rar_pkg::ONE - p_clamp;
            cost_reg <= stage_cost;
            last_reg <= last_stage;
        end
        if (cmd.j_init)
        begin
            qpow_reg <= q_reg;
            best_reg <= '0;
        end
        if (cmd.mul_q)
        begin
            qnext_reg <= 32'(prod_q >> rar_pkg::FRAC_BITS);
            cand_reg  <= 32'(prod_r >> rar_pkg::FRAC_BITS);
        end
        if (cmd.mul_r && cand_reg > best_reg)
            best_reg <= cand_reg;
        if (cmd.step)
            qpow_reg <= qnext_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg          <= '0;
            used_reg       <= '0;
            clr_reg        <= '0;
            cost_total_reg <= '0;
            zp_reg         <= 1'b0;
            zc_reg         <= 1'b0;
            res_reg        <= '0;
            st_reg         <= rar_pkg::ST_OK;
        end
        else
        begin
            if (cmd.load)
            begin
                j_reg          <= IW'(rar_pkg::MAX_SPARE);
                cost_total_reg <= ct_sum[32] ? 32'hFFFF_FFFF : ct_sum[31:0];
                if (p_clamp == '0)
                    zp_reg <= 1'b1;
                if (stage_cost == '0)
                    zc_reg <= 1'b1;
            end
            if (cmd.j_init)
                used_reg <= '0;
            if (cmd.step)
                used_reg <= used_plus[IW:0];
            if (cmd.j_dec)
                j_reg <= j_reg - 1'b1;
            if (cmd.clr_wr)
                clr_reg <= sts.clr_done ? '0 : clr_reg + 1'b1;
            if (cmd.clr_start)
            begin
                cost_total_reg <= '0;
                zp_reg         <= 1'b0;
                zc_reg         <= 1'b0;
            end
            if (cmd.fin_rd)
            begin
                res_reg <= '0;
                if (zp_reg)
                    st_reg <= rar_pkg::ST_ZERO_PROB;
                else if (cost_total_reg > {12'd0, total_budget})
                    st_reg <= rar_pkg::ST_SHORT;
                else if (spare > 32'(rar_pkg::MAX_SPARE))
                    st_reg <= rar_pkg::ST_SPARE;
                else if (zc_reg)
                    st_reg <= rar_pkg::ST_ZERO_COST;
                else
                    st_reg <= rar_pkg::ST_OK;
            end
            if (cmd.clr_start == 1'b0 && cmd.fin_rd == 1'b0 && st_reg == rar_pkg::ST_OK
                && cmd.load == 1'b0 && cmd.wr == 1'b0 && cmd.clr_wr == 1'b0
                && cmd.rd == 1'b0 && cmd.mul_q == 1'b0 && cmd.mul_r == 1'b0
                && cmd.j_init == 1'b0 && cmd.step == 1'b0 && !sts.j_zero)
                res_reg <= res_reg;
            else if (cmd.rd == 1'b0 && cmd.fin_rd == 1'b0 && cmd.clr_wr == 1'b0
                && cmd.load == 1'b0 && cmd.clr_start == 1'b0 && cmd.wr == 1'b0
                && cmd.mul_q == 1'b0 && cmd.mul_r == 1'b0 && cmd.j_init == 1'b0
                && cmd.step == 1'b0 && st_reg == rar_pkg::ST_OK && sts.j_zero
                && last_reg)
                res_reg <= rd_data_reg;
        end
    end
endmodule

/* src/redundancy_allocation_reliability_dp_core.sv */
// Reliability allocation core: one stage per beat, result on the last stage.
// Each stage walks budget entries 1024 down to 0: per entry it starts a search, then
//   per copy choice reads the row, multiplies, compares and steps, then writes the best.
// The pace is set by the dependent read, multiply and compare chain on one read port.
// After reset and after each result a clearing pass refills all 1025 row entries.
// Reset (rst_n, asynchronous) clears control state and total_budget.
`timescale 1ns / 1ps
`include "redundancy_allocation_reliability_dp_core_assert.svh"
module redundancy_allocation_reliability_dp_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // [31:0] stage_probability, [47:32] stage_cost
    input  logic        s_axis_tlast,  // last_stage
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [31:0] best_reliability, [34:32] status, zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic [1:0] ADDR_BUDGET = 2'd0;

    rar_pkg::rar_cmd_t cmd;
    rar_pkg::rar_sts_t sts;
    logic [19:0]       total_budget_reg;
    logic [31:0]       best_reliability;
    logic [2:0]        status;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_BUDGET) ? {12'd0, total_budget_reg} : 32'd0;

    // Hold the budget register; written in the access phase only.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_budget_reg <= '0;
        else if (psel && penable && pwrite && paddr == ADDR_BUDGET)
            total_budget_reg <= pwdata[19:0];
    end

    rar_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    rar_dp u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .stage_probability (s_axis_tdata[31:0]),
        .stage_cost        (s_axis_tdata[47:32]),
        .last_stage        (s_axis_tlast),
        .total_budget      (total_budget_reg),
        .cmd               (cmd),
        .sts               (sts),
        .best_reliability  (best_reliability),
        .status            (status)
    );

    assign m_axis_tdata = {5'd0, status, best_reliability};

    // A result with a fault status carries zero reliability.
    `RAR_ASSERT_IMP(a_fault_zero, clk, rst_n, m_axis_tvalid && status != rar_pkg::ST_OK, best_reliability == 32'd0)
    // Input is never taken while a result is pending.
    `RAR_ASSERT_IMP(a_no_overlap, clk, rst_n, m_axis_tvalid, !s_axis_tready)
    // A taken input starts work, so ready drops the next cycle.
    `RAR_ASSERT_NEXT(a_busy_after_load, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

/* tb/redundancy_allocation_reliability_dp_core_tb.sv */
// Testbench for the reliability allocation core: stream stages in, check results.
// Depends on rar_pkg and the core RTL; self-contained otherwise.
`timescale 1ns / 1ps
module redundancy_allocation_reliability_dp_core_tb;
    import rar_pkg::*;

    localparam logic [1:0] ADDR_TOTAL_BUDGET = 2'd0;
    // Clearing pass plus margin after the last result of a phase
    localparam int SETTLE_CYCLES = 1200;
    // Longer than a whole data set, so a result waits and the input stalls
    localparam int HOLD_OFF_CYCLES = 300000;

    // Running prediction of the core: one reliability row per data set
    class reliability_scoreboard;
        longint unsigned row[ROW_LEN];
        bit [31:0] cost_sum;
        bit        zero_prob;
        bit        zero_cost;
        bit [19:0] budget;
        logic [31:0] exp_rel[$];
        logic [2:0]  exp_status[$];
        int errors;

        function void clear_set();
            foreach (row[k])
                row[k] = ONE;
            cost_sum = '0;
            zero_prob = 1'b0;
            zero_cost = 1'b0;
        endfunction

        function longint unsigned qmul(longint unsigned a, longint unsigned b);
            return (a * b) >> FRAC_BITS;
        endfunction

        // Fold one accepted stage into the row; queue a result on the last one
        function void note_stage(logic [31:0] prob, logic [15:0] cost, logic last);
            longint unsigned p;
            longint unsigned q;
            longint unsigned best;
            longint unsigned qpow;
            longint unsigned cand;
            int used;
            bit [32:0] sum;
            p = (prob > ONE) ? ONE : prob;
            q = ONE - p;
            if (p == 0)
                zero_prob = 1'b1;
            if (cost == 0)
                zero_cost = 1'b1;
            sum = cost_sum + cost;
            cost_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            for (int j = MAX_SPARE; j >= 0; j--)
            begin
                best = 0;
                qpow = q;
                used = 0;
                forever
                begin
                    cand = qmul(row[j - used], ONE - qpow);
                    if (cand > best)
                        best = cand;
                    if (cost == 0 || used + cost > j)
                        break;
                    used += cost;
                    qpow = qmul(qpow, q);
                end
                row[j] = best;
            end
            if (!last)
                return;
            if (zero_prob)
            begin
                exp_status.push_back(ST_ZERO_PROB);
                exp_rel.push_back('0);
            end
            else if (cost_sum > budget)
            begin
                exp_status.push_back(ST_SHORT);
                exp_rel.push_back('0);
            end
            else if (budget - cost_sum > MAX_SPARE)
            begin
                exp_status.push_back(ST_SPARE);
                exp_rel.push_back('0);
            end
            else if (zero_cost)
            begin
                exp_status.push_back(ST_ZERO_COST);
                exp_rel.push_back('0);
            end
            else
            begin
                exp_status.push_back(ST_OK);
                exp_rel.push_back(row[budget - cost_sum][31:0]);
            end
            clear_set();
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [31:0] rel, logic [2:0] status);
            logic [31:0] want_rel;
            logic [2:0]  want_status;
            if (exp_status.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result rel=%h status=%0d", rel, status));
                return;
            end
            want_rel = exp_rel.pop_front();
            want_status = exp_status.pop_front();
            if (status !== want_status)
                report_mismatch($sformatf("status %0d, want %0d", status, want_status));
            if (rel !== want_rel)
                report_mismatch($sformatf("reliability %h, want %h", rel, want_rel));
        endtask

        function int pending();
            return exp_status.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;  // [31:0] stage_probability, [47:32] stage_cost
    logic        s_axis_tlast;  // last_stage
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;  // [31:0] best_reliability, [34:32] status, zero pad
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    reliability_scoreboard sb;
    bit quiet;      // no idling on either side in the final phase
    bit hold_req;   // ask the receiver for one long hold-off

    redundancy_allocation_reliability_dp_core uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Generous ceiling on the run time of the whole test
    initial
    begin
        #400_000_000;
        $display("simulation failed");
        $finish;
    end

    // Register write: setup cycle, then access cycle; idle only
    task write_budget(logic [19:0] value);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = ADDR_TOTAL_BUDGET;
        pwdata = {12'd0, value};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        sb.budget = value;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Offer one stage beat from a falling edge and hold it until accepted
    task send_stage(logic [31:0] prob, logic [15:0] cost, logic last);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 19);
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {cost, prob};
        s_axis_tlast = last;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_stage(prob, cost, last);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Pause the sender until every queued result is back, then let the clearing pass end
    task drain();
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Probability mix: mostly in range, some zero, some above one, some full width
    function logic [31:0] rand_prob();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return $urandom_range(32'h8000_0001, 32'hFFFF_FFFF);
            2:       return ONE;
            3:       return $urandom;
            default: return $urandom_range(1, 32'h7FFF_FFFF);
        endcase
    endfunction

    // Keep costs away from tiny values: a small cost walks many copy choices
    function logic [15:0] rand_cost();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return $urandom_range(64, 255);
            2:       return 16'hFFFF;
            default: return $urandom_range(256, 4000);
        endcase
    endfunction

    // One data set aimed at a spare inside the row, so real results come out
    task random_set();
        int n;
        int spent;
        int need;
        logic [15:0] cost;
        n = $urandom_range(1, 3);
        spent = 0;
        for (int k = 0; k < n - 1; k++)
        begin
            cost = rand_cost();
            spent += cost;
            send_stage(rand_prob(), cost, 1'b0);
        end
        need = int'(sb.budget) - spent - int'($urandom_range(0, 1100));
        if (need >= 64 && need <= 65535 && $urandom_range(0, 9) != 0)
            cost = need[15:0];
        else
            cost = rand_cost();
        send_stage(rand_prob(), cost, 1'b1);
    endtask

    // Receiver: random ready bursts, one long hold-off on request
    initial
    begin
        int burst;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            if (quiet)
                m_axis_tready = 1'b1;
            else
            begin
                m_axis_tready = ~m_axis_tready;
                burst = $urandom_range(1, 19);
                repeat (burst - 1)
                begin
                    @(negedge clk);
                    if (quiet || hold_req)
                        break;
                end
            end
        end
    end

    // Result monitor: check each accepted beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[31:0], m_axis_tdata[34:32]);
    end

    initial
    begin
        int waited;
        sb = new();
        sb.clear_set();
        sb.budget = '0;
        sb.errors = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        repeat (SETTLE_CYCLES) @(negedge clk);

        // Zero budget: zero probability wins, zero cost alone, budget short
        send_stage(32'd0, 16'd0, 1'b1);
        send_stage(ONE, 16'd0, 1'b1);
        send_stage(ONE, 16'd5000, 1'b1);
        drain();

        // Full budget: spare far beyond the row
        write_budget(20'hFFFFF);
        send_stage(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send_stage(32'h0000_0001, 16'd1, 1'b0);
        send_stage(32'h4000_0000, 16'hFFFF, 1'b1);
        drain();

        // Mid budget: normal sets, clamping above one, one small cost stage
        write_budget(20'd3000);
        send_stage(ONE >> 1, 16'd1000, 1'b0);
        send_stage(32'h4000_0000, 16'd1500, 1'b1);
        send_stage(32'h8000_0001, 16'd300, 1'b0);
        send_stage(32'h7FFF_FFFF, 16'd1700, 1'b1);
        send_stage(32'h7000_0000, 16'd16, 1'b0);
        send_stage(32'h0000_0001, 16'hFFFF, 1'b1);
        send_stage(32'h2000_0000, 16'd2000, 1'b0);
        send_stage(ONE, 16'd0, 1'b1);
        send_stage(32'h5555_5555, 16'd3000, 1'b1);
        send_stage(32'h0000_0000, 16'd100, 1'b0);
        send_stage(ONE, 16'd2000, 1'b1);
        drain();

        // Random phases over several budgets, the long hold-off in the first
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:       write_budget(20'($urandom_range(1000, 6000)));
                1:       write_budget(20'($urandom_range(0, 1024)));
                2:       write_budget(20'($urandom_range(60000, 70000)));
                default: write_budget(20'($urandom_range(2000, 9000)));
            endcase
            if (ph == 0)
                hold_req = 1'b1;
            quiet = (ph == 4);
            for (int s = 0; s < 8; s++)
                random_set();
            drain();
        end

        waited = 0;
        while (sb.pending() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
